[src/pdv_pkg.sv]
// Shared constants and types of the perspective divide and viewport block.
package pdv_pkg;

  // Field widths
  localparam int unsigned ClipW   = 32;
  localparam int unsigned ScreenW = 16;
  localparam int unsigned VpPosW  = 16;
  localparam int unsigned VpDimW  = 15;
  localparam int unsigned EpsW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Q16.16 one and the rounding half in Q.17
  localparam int unsigned FracW   = 16;
  localparam int unsigned ScaleW  = 17;

  // Divider geometry: 48-bit magnitude numerator, 32-bit magnitude divisor,
  // 33 quotient bits developed one per stage
  localparam int unsigned NumW     = 48;
  localparam int unsigned DenW     = 32;
  localparam int unsigned DivSteps = 33;
  localparam int unsigned LowW     = DivSteps;
  localparam int unsigned HiW      = NumW - LowW;
  localparam int unsigned DivLat   = DivSteps + 2;

  // Pipeline: input stage, divider, multiply, sum, output
  localparam int unsigned NStages  = DivLat + 4;

  // Screen arithmetic widths
  localparam int unsigned OffW  = ClipW + 1;
  localparam int unsigned ProdW = OffW + VpDimW + 1;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned ShW   = SumW - ScaleW;

  localparam logic signed [ClipW-1:0] QMax = {1'b0, {(ClipW-1){1'b1}}};
  localparam logic signed [ClipW-1:0] QMin = {1'b1, {(ClipW-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgVpX    = 3'd0,
    CfgVpY    = 3'd1,
    CfgVpW    = 3'd2,
    CfgVpH    = 3'd3,
    CfgWEps   = 3'd4
  } cfg_reg_e;

  // Flags that ride alongside the divider
  typedef struct packed {
    logic persp;
    logic fault;
    logic last;
  } side_t;

endpackage

[src/pdv_divider.sv]
// Pipelined restoring divider with sign fix-up and Q16.16 saturation.
module pdv_divider import pdv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [NumW-1:0]         num_i,
  input  logic [DenW-1:0]         den_i,
  input  logic                    neg_i,
  output logic signed [ClipW-1:0] quo_o
);

  logic [DenW-1:0] rem_q  [DivSteps+1];
  logic [LowW-1:0] low_q  [DivSteps+1];
  logic [DivSteps-1:0] quo_q [DivSteps+1];
  logic [DenW-1:0] den_q  [DivSteps+1];
  logic            ovf_q  [DivSteps+1];
  logic            neg_q  [DivSteps+1];
  logic            zero_q [DivSteps+1];

  logic [DenW-1:0] hi_ext;
  logic signed [ClipW-1:0] res_d, res_q;

  assign hi_ext = {{(DenW-HiW){1'b0}}, num_i[NumW-1:LowW]};

  // Set up: a quotient of 2^33 or more can only saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= (hi_ext >= den_i);
      rem_q[0]  <= (hi_ext >= den_i) ? '0 : hi_ext;
      low_q[0]  <= num_i[LowW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= neg_i;
      zero_q[0] <= (num_i == '0);
    end
  end

  // One quotient bit per stage
  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    logic          ge;
    assign trial = {rem_q[i], low_q[i][LowW-1]};
    assign diff  = trial - {1'b0, den_q[i]};
    assign ge    = (trial >= {1'b0, den_q[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        low_q[i+1]  <= {low_q[i][LowW-2:0], 1'b0};
        quo_q[i+1]  <= {quo_q[i][DivSteps-2:0], ge};
        den_q[i+1]  <= den_q[i];
        ovf_q[i+1]  <= ovf_q[i];
        neg_q[i+1]  <= neg_q[i];
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  // Apply sign and saturate
  always_comb begin
    logic [DivSteps-1:0] q;
    q = quo_q[DivSteps];
    if (zero_q[DivSteps]) begin
      res_d = '0;
    end else if (neg_q[DivSteps]) begin
      if (ovf_q[DivSteps] || q[DivSteps-1] || (q[ClipW-1] && (q[ClipW-2:0] != '0))) begin
        res_d = QMin;
      end else begin
        res_d = -$signed(q[ClipW-1:0]);
      end
    end else begin
      if (ovf_q[DivSteps] || (q[DivSteps-1:ClipW-1] != '0)) begin
        res_d = QMax;
      end else begin
        res_d = $signed(q[ClipW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign quo_o = res_q;

endmodule

[src/perspective_divide_viewport.sv]
// Perspective divide and viewport transform, top level.
// Takes one clip-space vertex per cycle while not stalled and returns 1/z, x/w, y/w in
// Q16.16 and the rounded, saturated pixel position, with a perspective-scale flag and a
// zero-divisor flag. Throughput is one vertex per clock while the output is not stalled;
// the three 35-stage restoring dividers (a set-up stage, 33 stages developing one quotient
// bit each and a sign fix-up stage) follow the input stage and precede the multiply, sum and output stages. A stall
// on the output freezes the whole pipeline while the output stage holds a request and
// is passed straight back as in_stall_o. Viewport registers are written through the
// plain write port and must only change while the pipeline is empty.
module perspective_divide_viewport import pdv_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDatW-1:0]        cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [ClipW-1:0]   clip_x_i,
  input  logic signed [ClipW-1:0]   clip_y_i,
  input  logic signed [ClipW-1:0]   clip_z_i,
  input  logic signed [ClipW-1:0]   clip_w_i,
  input  logic                      last_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ScreenW-1:0] screen_x_o,
  output logic signed [ScreenW-1:0] screen_y_o,
  output logic signed [ClipW-1:0]   ndc_x_o,
  output logic signed [ClipW-1:0]   ndc_y_o,
  output logic signed [ClipW-1:0]   depth_recip_o,
  output logic                      needs_persp_scale_o,
  output logic                      divide_fault_o,
  output logic                      last_out_o
);

  // Configuration registers
  logic signed [VpPosW-1:0] vp_x_q, vp_y_q;
  logic [VpDimW-1:0]        vp_w_q, vp_h_q;
  logic [EpsW-1:0]          eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_x_q <= '0;
      vp_y_q <= '0;
      vp_w_q <= VpDimW'(640);
      vp_h_q <= VpDimW'(480);
      eps_q  <= EpsW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgVpX:  vp_x_q <= $signed(cfg_data_i);
        CfgVpY:  vp_y_q <= $signed(cfg_data_i);
        CfgVpW:  vp_w_q <= cfg_data_i[VpDimW-1:0];
        CfgVpH:  vp_h_q <= cfg_data_i[VpDimW-1:0];
        CfgWEps: eps_q  <= cfg_data_i[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold everything while the output request is stalled
  logic               en;
  logic [NStages-1:0] vld_q;

  assign en         = !(vld_q[NStages-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStages-2:0], in_valid_i};
    end
  end

  // Input stage
  logic signed [ClipW-1:0] x_q, y_q, z_q, w_q;
  logic                    last_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q    <= clip_x_i;
      y_q    <= clip_y_i;
      z_q    <= clip_z_i;
      w_q    <= clip_w_i;
      last_q <= last_in_i;
    end
  end

  // Magnitudes and signs for the dividers
  logic [ClipW-1:0] ax, ay, az, aw;
  logic [NumW-1:0]  num_x, num_y, num_z;

  assign ax = x_q[ClipW-1] ? ClipW'(-x_q) : ClipW'(x_q);
  assign ay = y_q[ClipW-1] ? ClipW'(-y_q) : ClipW'(y_q);
  assign az = z_q[ClipW-1] ? ClipW'(-z_q) : ClipW'(z_q);
  assign aw = w_q[ClipW-1] ? ClipW'(-w_q) : ClipW'(w_q);

  assign num_x = {ax, {FracW{1'b0}}};
  assign num_y = {ay, {FracW{1'b0}}};
  assign num_z = NumW'(1) << (2 * FracW);

  // Flags
  logic signed [ClipW:0] dw;
  logic [ClipW:0]        adw;
  side_t                 side_d;

  assign dw  = {w_q[ClipW-1], w_q} - (ClipW+1)'(1 << FracW);
  assign adw = dw[ClipW] ? (ClipW+1)'(-dw) : (ClipW+1)'(dw);

  always_comb begin
    side_d.persp = (adw > {{(ClipW+1-EpsW){1'b0}}, eps_q});
    side_d.fault = (z_q == '0) || (w_q == '0);
    side_d.last  = last_q;
  end

  // Dividers
  logic signed [ClipW-1:0] nx, ny, dz;

  pdv_divider u_div_x (
    .clk_i (clk_i), .en_i (en), .num_i (num_x), .den_i (aw),
    .neg_i (x_q[ClipW-1] ^ w_q[ClipW-1]), .quo_o (nx)
  );
  pdv_divider u_div_y (
    .clk_i (clk_i), .en_i (en), .num_i (num_y), .den_i (aw),
    .neg_i (y_q[ClipW-1] ^ w_q[ClipW-1]), .quo_o (ny)
  );
  pdv_divider u_div_z (
    .clk_i (clk_i), .en_i (en), .num_i (num_z), .den_i (az),
    .neg_i (z_q[ClipW-1]), .quo_o (dz)
  );

  // Delay the flags alongside the dividers
  side_t side_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DivLat; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Multiply stage
  logic signed [OffW-1:0]  offx, offy;
  logic signed [ProdW-1:0] px_q, py_q;
  logic signed [ClipW-1:0] nx_m_q, ny_m_q, dz_m_q;
  side_t                   side_m_q;

  assign offx = OffW'(nx) + OffW'(1 << FracW);
  assign offy = OffW'(1 << FracW) - OffW'(ny);

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q     <= offx * $signed({1'b0, vp_w_q});
      py_q     <= offy * $signed({1'b0, vp_h_q});
      nx_m_q   <= nx;
      ny_m_q   <= ny;
      dz_m_q   <= dz;
      side_m_q <= side_q[DivLat-1];
    end
  end

  // Sum stage
  logic signed [SumW-1:0]  sx_q, sy_q;
  logic signed [ClipW-1:0] nx_s_q, ny_s_q, dz_s_q;
  side_t                   side_s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= (SumW'(vp_x_q) <<< ScaleW) + SumW'(px_q) + SumW'(1 << FracW);
      sy_q <= (SumW'(vp_y_q) <<< ScaleW) + SumW'(py_q) + SumW'(1 << FracW);
      nx_s_q   <= nx_m_q;
      ny_s_q   <= ny_m_q;
      dz_s_q   <= dz_m_q;
      side_s_q <= side_m_q;
    end
  end

  // Truncate toward zero and saturate to 16 bits
  function automatic logic signed [ScreenW-1:0] pix_sat(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] adj;
    logic signed [ShW-1:0]  q;
    adj = s + (s[SumW-1] ? SumW'((1 << ScaleW) - 1) : SumW'(0));
    q   = ShW'(adj >>> ScaleW);
    if (q > ShW'(32767)) begin
      return {1'b0, {(ScreenW-1){1'b1}}};
    end else if (q < -ShW'(32768)) begin
      return {1'b1, {(ScreenW-1){1'b0}}};
    end else begin
      return q[ScreenW-1:0];
    end
  endfunction

  // Output stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      screen_x_o          <= pix_sat(sx_q);
      screen_y_o          <= pix_sat(sy_q);
      ndc_x_o             <= nx_s_q;
      ndc_y_o             <= ny_s_q;
      depth_recip_o       <= dz_s_q;
      needs_persp_scale_o <= side_s_q.persp;
      divide_fault_o      <= side_s_q.fault;
      last_out_o          <= side_s_q.last;
    end
  end

  assign out_valid_o = vld_q[NStages-1];

  // Accepted requests enter the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  // Stage valids freeze while stalled
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved under stall");

  // A fault without zero z means zero w: ndc is saturated or zero
  a_wzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o && (depth_recip_o != QMax) |->
      (ndc_x_o == QMax) || (ndc_x_o == QMin) || (ndc_x_o == '0))
    else $error("zero w gave an unsaturated ndc");

endmodule

[sim/tb.sv]
// Self-checking testbench of the perspective divide and viewport block.
module tb;
  import pdv_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [ClipW-1:0] clip_x_i = '0, clip_y_i = '0, clip_z_i = '0, clip_w_i = '0;
  logic last_in_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [ScreenW-1:0] screen_x_o, screen_y_o;
  logic signed [ClipW-1:0] ndc_x_o, ndc_y_o, depth_recip_o;
  logic needs_persp_scale_o, divide_fault_o, last_out_o;

  typedef struct packed {
    logic signed [ScreenW-1:0] sx;
    logic signed [ScreenW-1:0] sy;
    logic signed [ClipW-1:0] nx;
    logic signed [ClipW-1:0] ny;
    logic signed [ClipW-1:0] depth;
    logic persp;
    logic fault;
    logic last;
  } vertex_out_t;

  vertex_out_t pending_vertices[$];
  int errors = 0;
  int vertices_sent = 0;
  int vertices_checked = 0;
  bit quiet_sender = 1'b0;
  bit quiet_receiver = 1'b0;

  // Shadow copy of the viewport registers
  longint vp_x = 0, vp_y = 0, vp_w = 640, vp_h = 480, w_eps = 1;

  perspective_divide_viewport dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat_quot(longint num, longint den);
    if (den == 0) return (num > 0) ? 64'sd2147483647 : ((num < 0) ? -64'sd2147483648 : 0);
    return clamp64(num / den, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // Project one vertex with the current viewport
  function automatic vertex_out_t project_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                                 logic signed [31:0] z, logic signed [31:0] w,
                                                 logic last);
    vertex_out_t r;
    longint lx, ly, lz, lw, nx, ny, dw, sx, sy;
    lx = x; ly = y; lz = z; lw = w;
    r.depth = 32'((lz == 0) ? 64'sd2147483647
                  : clamp64((64'sd1 <<< 32) / lz, -64'sd2147483648, 64'sd2147483647));
    nx = sat_quot(lx * 65536, lw);
    ny = sat_quot(ly * 65536, lw);
    dw = lw - 65536;
    if (dw < 0) dw = -dw;
    r.persp = dw > w_eps;
    r.fault = (lz == 0) || (lw == 0);
    r.last = last;
    sx = vp_x * 131072 + (nx + 65536) * vp_w + 65536;
    sy = vp_y * 131072 + (65536 - ny) * vp_h + 65536;
    r.sx = 16'(clamp64(sx / 131072, -32768, 32767));
    r.sy = 16'(clamp64(sy / 131072, -32768, 32767));
    r.nx = 32'(nx);
    r.ny = 32'(ny);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  // Receiver: random stall, check each result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        vertex_out_t e;
        if (pending_vertices.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = pending_vertices.pop_front();
          vertices_checked++;
          if (screen_x_o !== e.sx) report_mismatch("screen_x", screen_x_o, e.sx);
          if (screen_y_o !== e.sy) report_mismatch("screen_y", screen_y_o, e.sy);
          if (ndc_x_o !== e.nx) report_mismatch("ndc_x", ndc_x_o, e.nx);
          if (ndc_y_o !== e.ny) report_mismatch("ndc_y", ndc_y_o, e.ny);
          if (depth_recip_o !== e.depth) report_mismatch("depth_recip", depth_recip_o, e.depth);
          if (needs_persp_scale_o !== e.persp)
            report_mismatch("needs_persp_scale", needs_persp_scale_o, e.persp);
          if (divide_fault_o !== e.fault) report_mismatch("divide_fault", divide_fault_o, e.fault);
          if (last_out_o !== e.last) report_mismatch("last_out", last_out_o, e.last);
        end
      end
      out_stall_i <= quiet_receiver ? 1'b0 : ($urandom_range(99) < 33);
    end
  end

  // Send one request, with a random gap first, and hold until accepted
  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic signed [31:0] w, logic last);
    while (!quiet_sender && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    clip_x_i <= x; clip_y_i <= y; clip_z_i <= z; clip_w_i <= w; last_in_i <= last;
    pending_vertices.push_back(project_vertex(x, y, z, w, last));
    do @(posedge clk_i); while (in_stall_o);
    vertices_sent++;
  endtask

  // Drain every pending result, then let the pipeline settle
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (NStages + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgVpX: vp_x = $signed(val);
      CfgVpY: vp_y = $signed(val);
      CfgVpW: vp_w = val[14:0];
      CfgVpH: vp_h = val[14:0];
      CfgWEps: w_eps = val;
      default: ;
    endcase
  endtask

  task automatic set_viewport(logic [15:0] x, logic [15:0] y, logic [15:0] w, logic [15:0] h,
                              logic [15:0] eps);
    drain_pipeline();
    write_reg(CfgVpX, x); write_reg(CfgVpY, y); write_reg(CfgVpW, w);
    write_reg(CfgVpH, h); write_reg(CfgWEps, eps);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_clip();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $signed($urandom_range(262143)) - 131072;
      2: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return 32'h0001_0000 + $signed($urandom_range(15)) - 8;
      4: return $urandom_range(2) == 0 ? 32'h0 : $urandom() >> $urandom_range(31);
      default: return $signed($urandom_range(1 << 20)) - (1 << 19);
    endcase
  endfunction

  // Field extremes, zero divisors and the w near one cases at reset settings
  task automatic test_directed();
    send_vertex(0, 0, 32'h10000, 32'h10000, 0);
    send_vertex(32'h10000, 32'h10000, 32'h10000, 32'h10000, 1);
    send_vertex(32'hFFFF0000, 32'hFFFF0000, 32'h20000, 32'h10000, 0);
    send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h10000, 1);
    send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h1, 0);
    send_vertex(5, -5, 0, 32'h10000, 0);
    send_vertex(5, -5, 32'h10000, 0, 1);
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(-3, 7, 1, 32'hFFFFFFFF, 0);
    send_vertex(1, 1, 32'hFFFFFFFF, 32'h80000000, 1);
    send_vertex(1, 1, 1, 32'h10001, 0);
    send_vertex(1, 1, 1, 32'h10002, 0);
    send_vertex(1, 1, 1, 32'hFFFF, 0);
    send_vertex(1, 1, 1, 32'hFFFE, 1);
  endtask

  // Viewport extremes, each with a few vertices
  task automatic test_viewport_extremes();
    set_viewport(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    repeat (8) send_vertex(rand_clip(), rand_clip(), rand_clip(), rand_clip(), $urandom());
    set_viewport(16'h7FFF, 16'h7FFF, 0, 0, 0);
    repeat (8) send_vertex(rand_clip(), rand_clip(), rand_clip(), rand_clip(), $urandom());
  endtask

  // Random vertices over several random viewports, one stretch without idling
  task automatic test_random_stream();
    for (int phase = 0; phase < 6; phase++) begin
      set_viewport($urandom(), $urandom(), $urandom_range(2000), $urandom_range(2000),
                   $urandom_range(3) == 0 ? $urandom() : $urandom_range(64));
      quiet_sender = (phase == 3);
      quiet_receiver = (phase == 3);
      repeat (120) send_vertex(rand_clip(), rand_clip(), rand_clip(), rand_clip(), $urandom());
    end
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_viewport_extremes();
    test_random_stream();
    drain_pipeline();
    $display("sent %0d vertices, checked %0d, over 9 viewport settings",
             vertices_sent, vertices_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[files.f]
src/pdv_pkg.sv
src/pdv_divider.sv
src/perspective_divide_viewport.sv
sim/tb.sv
